>>> sv/cpbm_pkg.sv
`timescale 1ns / 1ps

package cpbm_pkg;

  // Access kinds carried in the slave-side tuser.
  typedef enum logic [1:0] {
    FUNC_PRG_RD = 2'd0,
    FUNC_PRG_WR = 2'd1,
    FUNC_VID_RD = 2'd2,
    FUNC_VID_WR = 2'd3
  } func_e;

  // Result destinations carried in the master-side tuser.
  typedef enum logic [2:0] {
    TGT_BUS     = 3'd0,
    TGT_ROM     = 3'd1,
    TGT_VRAM    = 3'd2,
    TGT_PATTERN = 3'd3,
    TGT_ABSORB  = 3'd4
  } target_e;

  // Board revision codes.
  localparam logic [2:0] REV_PLAIN_A = 3'd0;
  localparam logic [2:0] REV_MULTI_A = 3'd1;
  localparam logic [2:0] REV_PLAIN_B = 3'd2;
  localparam logic [2:0] REV_MULTI_B = 3'd3;
  localparam logic [2:0] REV_ONESCR  = 3'd4;

  // Configuration register indexes.
  localparam logic [1:0] CFG_IDX_REVISION = 2'd0;
  localparam logic [1:0] CFG_IDX_MIRROR   = 2'd1;

  localparam int unsigned ROM_AW  = 18;
  localparam int unsigned VRAM_AW = 11;

  typedef struct packed {
    logic [2:0] revision;
    logic       horiz;
  } cfg_t;

  typedef struct packed {
    logic [3:0] bank;
    logic [1:0] block;
    logic       page;
  } map_state_t;

  typedef struct packed {
    target_e              target;
    logic [ROM_AW-1:0]    rom_address;
    logic [VRAM_AW-1:0]   vram_address;
    logic [7:0]           data_out;
  } result_t;

  // Revisions above the last defined one behave as the first plain board.
  function automatic logic [2:0] eff_revision(input logic [2:0] rev);
    eff_revision = (rev > REV_ONESCR) ? REV_PLAIN_A : rev;
  endfunction

  function automatic logic is_multicart(input logic [2:0] rev);
    is_multicart = (rev == REV_MULTI_A) || (rev == REV_MULTI_B);
  endfunction

endpackage

>>> sv/cpbm_regs.sv
`timescale 1ns / 1ps

module cpbm_regs
  import cpbm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i,
  input  logic        prg_we_i,
  input  logic [15:0] prg_addr_i,
  input  logic [7:0]  prg_data_i,
  output cfg_t        cfg_o,
  output map_state_t  state_o
);

  cfg_t       cfg_q, cfg_d;
  map_state_t state_q, state_d;
  logic [2:0] rev;
  logic       multi;

  assign rev   = eff_revision(cfg_q.revision);
  assign multi = is_multicart(rev);

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_IDX_REVISION: cfg_d.revision = cfg_data_i[2:0];
        CFG_IDX_MIRROR:   cfg_d.horiz    = cfg_data_i[0];
        default:          cfg_d          = cfg_q;
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    if (prg_we_i) begin
      if (multi && (prg_addr_i[15:14] == 2'b10)) begin
        state_d.block = prg_data_i[4:3];
      end
      if ((rev == REV_ONESCR) && (prg_addr_i[15:13] == 3'b100)) begin
        state_d.page = prg_data_i[4];
      end
      if (prg_addr_i[15:14] == 2'b11) begin
        if (multi) begin
          state_d.bank = {2'b00, prg_data_i[1:0]};
        end else if (rev == REV_ONESCR) begin
          state_d.bank = {1'b0, prg_data_i[2:0]};
        end else begin
          state_d.bank = prg_data_i[3:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q   <= '0;
      state_q <= '0;
    end else begin
      cfg_q   <= cfg_d;
      state_q <= state_d;
    end
  end

  assign cfg_o   = cfg_q;
  assign state_o = state_q;

endmodule

>>> sv/cpbm_decode.sv
`timescale 1ns / 1ps

module cpbm_decode
  import cpbm_pkg::*;
(
  input  func_e       func_i,
  input  logic [15:0] addr_i,
  input  logic [7:0]  data_i,
  input  cfg_t        cfg_i,
  input  map_state_t  state_i,
  output result_t     result_o
);

  logic [2:0] rev;
  logic       multi;

  assign rev   = eff_revision(cfg_i.revision);
  assign multi = is_multicart(rev);

  always_comb begin
    result_o = '0;
    result_o.target = TGT_BUS;
    unique case (func_i)
      FUNC_PRG_RD: begin
        if (!addr_i[15]) begin
          result_o.target   = TGT_BUS;
          result_o.data_out = data_i;
        end else begin
          result_o.target = TGT_ROM;
          if (!addr_i[14]) begin
            // Block and bank fields overlap in bits 17:16, as on the board.
            result_o.rom_address = {state_i.block, 16'h0000}
                                 | {state_i.bank, 14'h0000}
                                 | {4'h0, addr_i[13:0]};
          end else if (multi) begin
            result_o.rom_address = {state_i.block, 2'b11, addr_i[13:0]};
          end else begin
            result_o.rom_address = {4'hf, addr_i[13:0]};
          end
        end
      end
      FUNC_PRG_WR: begin
        result_o.target = TGT_ABSORB;
      end
      FUNC_VID_RD, FUNC_VID_WR: begin
        result_o.data_out = data_i;
        if (addr_i[13]) begin
          result_o.target = TGT_VRAM;
          if (rev == REV_ONESCR) begin
            result_o.vram_address = {state_i.page, addr_i[9:0]};
          end else if (cfg_i.horiz) begin
            result_o.vram_address = {addr_i[11], addr_i[9:0]};
          end else begin
            result_o.vram_address = {addr_i[10], addr_i[9:0]};
          end
        end else begin
          result_o.target = TGT_PATTERN;
        end
      end
      default: begin
        result_o.target = TGT_BUS;
      end
    endcase
  end

endmodule

>>> sv/cartridge_prg_bank_mapper.sv
`timescale 1ns / 1ps

// Cartridge program-bank mapper. Each slave-side word is one bus access
// (program read or write, video read or write) and produces exactly one
// master-side word telling where the access goes: open bus, program ROM with
// an 18-bit byte address, the 2 KiB nametable RAM with an 11-bit address, the
// base board pattern space, or a write absorbed by the mapper registers.
// The block sustains one word per clock cycle while the master side is ready.
// A word passes through the input register and then the result register, and
// the mapping plus the bank/block/page register update happen between them.
// The input side stays ready while a finished result waits, as long as the
// input register is empty or moves forward in the same cycle. Configuration
// writes (board revision, mirroring) are always accepted and must only be
// issued while no word is in flight.
module cartridge_prg_bank_mapper
  import cpbm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // Slave side: access words.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata fields from bit 0: bus_address[15:0], bus_data[23:16].
  input  logic [23:0] s_axis_tdata,
  // tuser fields from bit 0: func[1:0].
  input  logic [1:0]  s_axis_tuser,
  // Master side: result words.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata fields from bit 0: rom_address[17:0], vram_address[28:18],
  // data_out[36:29], zero fill [39:37].
  output logic [39:0] m_axis_tdata,
  // tuser fields from bit 0: target[2:0].
  output logic [2:0]  m_axis_tuser,
  // Configuration write channel.
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i
);

  // Input register stage.
  logic        in_valid_q, in_valid_d;
  func_e       in_func_q;
  logic [15:0] in_addr_q;
  logic [7:0]  in_data_q;

  // Result register stage.
  logic        out_valid_q, out_valid_d;
  result_t     out_q;

  logic        s_accept;
  logic        advance;
  cfg_t        cfg;
  map_state_t  map_state;
  result_t     result;

  // A word moves into the result register when that register is empty or
  // is being emptied in the same cycle.
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  assign in_valid_d  = s_accept || (in_valid_q && !advance);
  assign out_valid_d = advance || (out_valid_q && !m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      in_func_q <= func_e'(s_axis_tuser);
      in_addr_q <= s_axis_tdata[15:0];
      in_data_q <= s_axis_tdata[23:16];
    end
    if (advance) begin
      out_q <= result;
    end
  end

  // Mapper registers are updated by a program write exactly when that word
  // leaves the input register, so later words see the new bank settings.
  cpbm_regs u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .prg_we_i    (advance && (in_func_q == FUNC_PRG_WR)),
    .prg_addr_i  (in_addr_q),
    .prg_data_i  (in_data_q),
    .cfg_o       (cfg),
    .state_o     (map_state)
  );

  cpbm_decode u_decode (
    .func_i   (in_func_q),
    .addr_i   (in_addr_q),
    .data_i   (in_data_q),
    .cfg_i    (cfg),
    .state_i  (map_state),
    .result_o (result)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.target;
  assign m_axis_tdata  = {3'b000, out_q.data_out, out_q.vram_address, out_q.rom_address};

  // Bank, block and page only change when a word moves to the result stage.
  a_state_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(map_state))
    else $error("mapper registers changed without a word advancing");

  // A ROM result never carries data or a nametable address.
  a_rom_clean : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_q.target == TGT_ROM)) |->
      ((out_q.data_out == 8'h00) && (out_q.vram_address == '0)))
    else $error("ROM result with stray data or nametable address");

  // Only nametable results carry a nametable address.
  a_vram_only : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_q.vram_address != '0)) |-> (out_q.target == TGT_VRAM))
    else $error("nametable address on a non-nametable result");

  // An absorbed write produces an all-zero payload.
  a_absorb_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_q.target == TGT_ABSORB)) |->
      ((out_q.rom_address == '0) && (out_q.data_out == 8'h00)))
    else $error("absorbed write with nonzero payload");

endmodule
